[src/udp_packet_size_checker_unit_assert.svh]
// Assertion macros for the UDP packet size checker unit.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef UDP_PACKET_SIZE_CHECKER_UNIT_ASSERT_SVH
`define UDP_PACKET_SIZE_CHECKER_UNIT_ASSERT_SVH
`ifndef SYNTH
// Checked property, disabled while reset is high.
`define UPSC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property, evaluated through reset as well.
`define UPSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UPSC_ASSERT(lbl, clk, rst, prop, msg)
`define UPSC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

[src/upsc_pkg.sv]
// Shared types and constants of the UDP packet size checker.
// No dependencies; imported by the interfaces and all modules.
package upsc_pkg;

   localparam int MAX_PACKET_BYTES = 16384;
   localparam int COUNT_W          = 15;
   localparam int ITEM_W           = COUNT_W - 3;
   localparam int TOTAL_W          = 35;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 15;

   localparam logic [31:0] SPEAD_MAGIC     = 32'h5304_0305;
   localparam int          SPEAD_MIN_BYTES = 32;
   localparam logic [15:0] LENGTH_ITEM_ID  = 16'd4;
   localparam logic        FORMAT_SPEAD    = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CHECK_FORMAT  = 1'b0,
      CSR_EXPECTED_SIZE = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic               check_format;
      logic [COUNT_W-1:0] expected_size;
   } cfg_type;

   typedef struct packed {
      logic               status;
      logic [COUNT_W-1:0] packet_length;
   } verdict_type;

endpackage

[src/upsc_if.sv]
// Request and response channel interfaces of the UDP packet size checker.
// Depends on upsc_pkg for the field widths.
interface upsc_req_if import upsc_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface upsc_rsp_if import upsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               status;
   logic [COUNT_W-1:0] packet_length;

   modport source (output valid, output status, output packet_length, input ready);
   modport sink   (input valid, input status, input packet_length, output ready);
endinterface

[src/udp_packet_size_checker_unit.sv]
// Top level of the UDP packet size checker: input stage, CSRs, result register.
// Depends on upsc_pkg, upsc_if, upsc_parser and the assertion macro header.
//
//  channel | dir | payload                       | transfer
//  req     | in  | data_byte[7:0], last_byte     | valid & ready
//  rsp     | out | status, packet_length[14:0]   | valid & ready, one per packet
//  csr     | in  | index[0], write data[14:0]    | write enable, no wait
//
// One request per cycle while ready is high; a verdict goes from the input
// register through the parser into the result register once its last byte
// is taken, and is held there until it is accepted.
// Request ready drops only while a finished verdict waits in the result
// register and the staged byte is also the last byte of a packet.
// Reset is synchronous and clears CSRs, staging valids and all parse state.

`include "udp_packet_size_checker_unit_assert.svh"

module udp_packet_size_checker_unit import upsc_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   upsc_req_if.sink               req_chan,
   upsc_rsp_if.source             rsp_chan,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type            cfg_ff;
   logic               s1_valid_ff;
   logic [7:0]         s1_byte_ff;
   logic               s1_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_status_ff;
   logic [COUNT_W-1:0] rsp_length_ff;
   logic               s1_adv;
   logic               rsp_stalled;
   verdict_type        verdict;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CHECK_FORMAT:  cfg_ff.check_format  <= csr_write_data[0];
            CSR_EXPECTED_SIZE: cfg_ff.expected_size <= csr_write_data[COUNT_W-1:0];
         endcase
      end
   end

   assign rsp_stalled    = rsp_valid_ff && !rsp_chan.ready;
   assign s1_adv         = s1_valid_ff && !(s1_last_ff && rsp_stalled);
   assign req_chan.ready = !s1_valid_ff || s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         s1_byte_ff <= req_chan.data_byte;
         s1_last_ff <= req_chan.last_byte;
      end
   end

   upsc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .step_en   (s1_adv),
      .data_byte (s1_byte_ff),
      .last_byte (s1_last_ff),
      .verdict   (verdict)
   );

   always_comb begin
      if (s1_adv && s1_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && s1_last_ff) begin
         rsp_status_ff <= verdict.status;
         rsp_length_ff <= verdict.packet_length;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.packet_length = rsp_length_ff;

   `UPSC_ASSERT(a_last_gives_rsp, clock, reset, s1_adv && s1_last_ff |=> rsp_valid_ff, "verdict not registered")
   `UPSC_ASSERT(a_ready_low_cause, clock, reset, !req_chan.ready |-> s1_valid_ff && s1_last_ff && rsp_valid_ff, "request stalled without cause")
   `UPSC_ASSERT(a_no_overwrite, clock, reset, rsp_stalled |-> !(s1_adv && s1_last_ff), "pending verdict overwritten")

endmodule

[src/upsc_parser.sv]
// Per-packet byte parser and verdict logic of the UDP packet size checker.
// Depends on upsc_pkg and the assertion macro header.
`include "udp_packet_size_checker_unit_assert.svh"

module upsc_parser import upsc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        step_en,
   input  logic [7:0]  data_byte,
   input  logic        last_byte,
   output verdict_type verdict
);

   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [31:0]        recent_bytes_ff, recent_bytes_in;
   logic [15:0]        item_total_ff, item_total_in;
   logic               length_found_ff, length_found_in;
   logic [31:0]        payload_length_ff, payload_length_in;
   logic               magic_bad_ff, magic_bad_in;
   logic [COUNT_W-1:0] learned_size_ff, learned_size_in;

   logic               room;
   logic [ITEM_W-1:0]  item_idx;
   logic [COUNT_W-1:0] size;
   logic [TOTAL_W-1:0] total;
   logic               spead_bad;
   logic               status;

   always_comb begin
      byte_count_in     = byte_count_ff;
      recent_bytes_in   = recent_bytes_ff;
      item_total_in     = item_total_ff;
      length_found_in   = length_found_ff;
      payload_length_in = payload_length_ff;
      magic_bad_in      = magic_bad_ff;
      learned_size_in   = learned_size_ff;

      room     = byte_count_ff < COUNT_W'(MAX_PACKET_BYTES);
      item_idx = byte_count_ff[COUNT_W-1:3] - ITEM_W'(1);

      // bytes past the maximum are dropped, the count saturates
      if (room) begin
         recent_bytes_in = {recent_bytes_ff[23:0], data_byte};
         byte_count_in   = byte_count_ff + COUNT_W'(1);
         if (byte_count_ff == COUNT_W'(3)) begin
            magic_bad_in = recent_bytes_in != SPEAD_MAGIC;
         end else if (byte_count_ff == COUNT_W'(7)) begin
            item_total_in = recent_bytes_in[15:0];
         end else if (byte_count_ff >= COUNT_W'(8) && !length_found_ff) begin
            // first half of an item is its id word, second half its value
            if (byte_count_ff[2:0] == 3'd3) begin
               payload_length_in = recent_bytes_in;
            end else if (byte_count_ff[2:0] == 3'd7
                         && {4'b0, item_idx} < item_total_ff
                         && payload_length_ff[23:8] == LENGTH_ITEM_ID) begin
               payload_length_in = recent_bytes_in;
               length_found_in   = 1'b1;
            end
         end
      end

      size  = (cfg.expected_size != '0) ? cfg.expected_size : learned_size_ff;
      total = TOTAL_W'(8) + {16'b0, item_total_in, 3'b000}
            + {3'b0, payload_length_in};
      spead_bad = byte_count_in < COUNT_W'(SPEAD_MIN_BYTES) || magic_bad_in
               || !length_found_in || total != {20'b0, byte_count_in};

      if (size == '0) begin
         status = 1'b0;
      end else if (cfg.check_format == FORMAT_SPEAD) begin
         status = spead_bad;
      end else begin
         status = byte_count_in != size;
      end

      verdict.status        = status;
      verdict.packet_length = byte_count_in;

      if (last_byte) begin
         if (size == '0) begin
            learned_size_in = byte_count_in;
         end
         byte_count_in     = '0;
         recent_bytes_in   = '0;
         item_total_in     = '0;
         length_found_in   = 1'b0;
         payload_length_in = '0;
         magic_bad_in      = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff     <= '0;
         recent_bytes_ff   <= '0;
         item_total_ff     <= '0;
         length_found_ff   <= 1'b0;
         payload_length_ff <= '0;
         magic_bad_ff      <= 1'b0;
         learned_size_ff   <= '0;
      end else if (step_en) begin
         byte_count_ff     <= byte_count_in;
         recent_bytes_ff   <= recent_bytes_in;
         item_total_ff     <= item_total_in;
         length_found_ff   <= length_found_in;
         payload_length_ff <= payload_length_in;
         magic_bad_ff      <= magic_bad_in;
         learned_size_ff   <= learned_size_in;
      end
   end

   `UPSC_ASSERT(a_count_max, clock, reset, byte_count_ff <= COUNT_W'(MAX_PACKET_BYTES), "byte count above maximum")
   `UPSC_ASSERT(a_clear_on_last, clock, reset, step_en && last_byte |=> byte_count_ff == '0, "count not cleared at packet end")
   `UPSC_ASSERT(a_found_has_items, clock, reset, length_found_ff |-> item_total_ff != '0, "length item found beyond item count")
   `UPSC_ASSERT(a_learned_kept, clock, reset, learned_size_ff != '0 |=> $stable(learned_size_ff), "learned size changed")

endmodule

[dv/upsc_tb_pkg.sv]
// Verdict tracker for the UDP packet size checker testbench: predicts one verdict
// per packet from the accepted bytes and checks the verdicts the block returns.
// Depends on upsc_pkg for widths, constants and the verdict type.
package upsc_tb_pkg;
   import upsc_pkg::*;

   class verdict_tracker;
      bit                 spead_mode;
      bit [COUNT_W-1:0]   size_setting;
      bit [COUNT_W-1:0]   learned_size;
      bit [COUNT_W-1:0]   byte_count;
      bit [31:0]          window;
      bit [15:0]          item_count;
      bit                 length_found;
      bit [31:0]          payload_length;
      bit                 magic_bad;
      verdict_type        pending_verdicts[$];
      int                 mismatches;
      int                 packets;
      int                 rejected;
      int                 spead_accepts;
      int                 saturated;

      function void set_config(bit spead, bit [COUNT_W-1:0] size);
         spead_mode   = spead;
         size_setting = size;
      endfunction

      function void take_byte(bit [7:0] data, bit last);
         int unsigned      pos;
         int unsigned      slot_pos;
         bit [COUNT_W-1:0] size;
         bit [TOTAL_W-1:0] total;
         verdict_type      verdict;
         pos = byte_count;
         // bytes past the maximum are dropped, count saturates
         if (pos < MAX_PACKET_BYTES) begin
            window = {window[23:0], data};
            if (pos == 3) begin
               magic_bad = (window != SPEAD_MAGIC);
            end else if (pos == 7) begin
               item_count = window[15:0];
            end else if (pos >= 8 && !length_found) begin
               slot_pos = pos - 8;
               // first half of an item carries its id, second half its value
               if (slot_pos[2:0] == 3'd3) begin
                  payload_length = window;
               end else if (slot_pos[2:0] == 3'd7 && (slot_pos >> 3) < item_count
                            && payload_length[23:8] == LENGTH_ITEM_ID) begin
                  payload_length = window;
                  length_found   = 1'b1;
               end
            end
            byte_count = byte_count + 1'b1;
         end
         if (!last) return;

         size = (size_setting != 0) ? size_setting : learned_size;
         verdict.packet_length = byte_count;
         if (size == 0) begin
            learned_size   = byte_count;
            verdict.status = 1'b0;
         end else if (spead_mode) begin
            total = item_count;
            total = (total << 3) + 8 + payload_length;
            verdict.status = byte_count < SPEAD_MIN_BYTES || magic_bad || !length_found
                             || total != byte_count;
            if (!verdict.status) spead_accepts++;
         end else begin
            verdict.status = (byte_count != size);
         end
         pending_verdicts.push_back(verdict);
         packets++;
         if (verdict.status) rejected++;
         if (byte_count == MAX_PACKET_BYTES) saturated++;

         byte_count     = '0;
         window         = '0;
         item_count     = '0;
         length_found   = 1'b0;
         payload_length = '0;
         magic_bad      = 1'b0;
      endfunction

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      task match_verdict(logic status, logic [COUNT_W-1:0] length);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            report_mismatch($sformatf("verdict status=%0b length=%0d with no packet pending",
                                      status, length));
            return;
         end
         want = pending_verdicts.pop_front();
         if (status !== want.status)
            report_mismatch($sformatf("status %0b, predicted %0b (length %0d)",
                                      status, want.status, want.packet_length));
         if (length !== want.packet_length)
            report_mismatch($sformatf("packet_length %0d, predicted %0d",
                                      length, want.packet_length));
      endtask
   endclass

endpackage

[dv/tb_top.sv]
// Top of the UDP packet size checker testbench: directed and random packets in
// fixed and SPEAD modes, random idling on both channels. Depends on upsc_pkg,
// upsc_if, upsc_tb_pkg and the udp_packet_size_checker_unit RTL.
module tb_top;
   import upsc_pkg::*;
   import upsc_tb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_write_en;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   upsc_req_if req_if ();
   upsc_rsp_if rsp_if ();

   udp_packet_size_checker_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_if),
      .rsp_chan       (rsp_if),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   verdict_tracker tracker;
   bit             steady;
   int unsigned    bytes_sent;
   bit [7:0]       packet_bytes[$];

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
         tracker.match_verdict(rsp_if.status, rsp_if.packet_length);
      rsp_if.ready <= steady || ($urandom_range(99) >= 10);
   end

   task automatic send_byte(bit [7:0] data, bit last);
      if (!steady && $urandom_range(99) < 10) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.data_byte <= data;
      req_if.last_byte <= last;
      @(posedge clock);
      while (req_if.ready !== 1'b1) @(posedge clock);
      tracker.take_byte(data, last);
      bytes_sent++;
   endtask

   task automatic send_packet();
      for (int i = 0; i < packet_bytes.size(); i++)
         send_byte(packet_bytes[i], i == packet_bytes.size() - 1);
   endtask

   // hold off until every verdict is back, then let the pipeline settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (tracker.pending_verdicts.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_config(bit spead, bit [COUNT_W-1:0] size);
      csr_write_en   <= 1'b1;
      csr_index      <= CSR_CHECK_FORMAT;
      csr_write_data <= CSR_DATA_W'(spead);
      @(posedge clock);
      csr_index      <= CSR_EXPECTED_SIZE;
      csr_write_data <= size;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      tracker.set_config(spead, size);
      repeat (2) @(posedge clock);
   endtask

   function automatic void fill_random(int len);
      packet_bytes.delete();
      repeat (len) packet_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void truncate_packet(int keep);
      while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
   endfunction

   // header, n items of 8 bytes (length item in length_slot, -1 for none), payload
   function automatic void make_spead(int n_items, int length_slot, bit [31:0] claimed,
                                      int payload_bytes);
      bit [31:0] word;
      bit [15:0] id;
      packet_bytes.delete();
      word = SPEAD_MAGIC;
      for (int k = 3; k >= 0; k--) packet_bytes.push_back(word[8*k +: 8]);
      packet_bytes.push_back(8'($urandom_range(255)));
      packet_bytes.push_back(8'($urandom_range(255)));
      packet_bytes.push_back(n_items[15:8]);
      packet_bytes.push_back(n_items[7:0]);
      for (int i = 0; i < n_items; i++) begin
         id = 16'($urandom_range(16'hFFFF));
         if (id == LENGTH_ITEM_ID) id = id + 1'b1;
         word = $urandom;
         if (i == length_slot) begin
            id   = LENGTH_ITEM_ID;
            word = claimed;
         end
         packet_bytes.push_back(8'($urandom_range(255)));
         packet_bytes.push_back(id[15:8]);
         packet_bytes.push_back(id[7:0]);
         packet_bytes.push_back(8'($urandom_range(255)));
         for (int k = 3; k >= 0; k--) packet_bytes.push_back(word[8*k +: 8]);
      end
      repeat (payload_bytes) packet_bytes.push_back(8'($urandom_range(255)));
   endfunction

   function automatic void random_spead_packet();
      int n_items;
      int slot;
      int payload;
      int pick;
      n_items = $urandom_range(0, 5);
      slot    = (n_items == 0 || $urandom_range(9) == 0) ? -1 : $urandom_range(0, n_items - 1);
      payload = $urandom_range(0, 40);
      make_spead(n_items, slot, payload, payload);
      pick = $urandom_range(99);
      if (pick < 65) begin
         // well formed
      end else if (pick < 70) begin
         packet_bytes[$urandom_range(0, 3)] ^= 8'h01 << $urandom_range(0, 7);
      end else if (pick < 75) begin
         packet_bytes.push_back(8'($urandom_range(255)));
      end else if (pick < 80) begin
         void'(packet_bytes.pop_back());
      end else if (pick < 85) begin
         truncate_packet($urandom_range(1, packet_bytes.size()));
      end else if (pick < 90) begin
         packet_bytes[$urandom_range(6, 7)] = 8'($urandom_range(255));
      end else if (pick < 94) begin
         make_spead(n_items, slot, $urandom, payload);
      end else begin
         fill_random($urandom_range(1, 40));
      end
   endfunction

   function automatic void random_fixed_packet(int expected);
      int pick;
      int len;
      pick = $urandom_range(99);
      if (pick < 50) len = expected;
      else if (pick < 60) len = expected + 1;
      else if (pick < 70) len = (expected > 1) ? expected - 1 : 2;
      else len = $urandom_range(1, 64);
      fill_random(len);
   endfunction

   initial begin
      int unsigned      random_start;
      int               left_in_setting;
      bit               spead;
      bit [COUNT_W-1:0] size;
      tracker = new();
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.data_byte <= '0;
      req_if.last_byte <= 1'b0;
      csr_write_en   <= 1'b0;
      csr_index      <= CSR_CHECK_FORMAT;
      csr_write_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // nothing to compare with yet: first packet sets the learned size
      write_config(FORMAT_SPEAD, '0);
      packet_bytes = '{8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80};
      send_packet();
      make_spead(2, 0, 24, 24);
      send_packet();
      wait_drained();

      // fixed mode against the learned size
      write_config(1'b0, '0);
      packet_bytes = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_packet();
      fill_random(4);
      send_packet();
      fill_random(6);
      send_packet();
      packet_bytes = '{8'h00};
      send_packet();
      wait_drained();

      // largest expected size
      write_config(1'b0, COUNT_W'(MAX_PACKET_BYTES));
      packet_bytes = '{8'hFF};
      send_packet();
      wait_drained();

      // SPEAD header checks
      write_config(FORMAT_SPEAD, COUNT_W'(1));
      make_spead(3, 1, 16, 16);
      send_packet();
      make_spead(3, 1, 16, 16);
      packet_bytes[2] ^= 8'h10;
      send_packet();
      make_spead(2, 0, 20, 21);
      send_packet();
      make_spead(1, 0, 0, 0);
      send_packet();
      make_spead(3, -1, 20, 20);
      send_packet();
      make_spead(2, 1, 20, 20);
      packet_bytes[7] = 8'd1;          // length item lies past the item count
      send_packet();
      make_spead(4, 3, 20, 20);
      truncate_packet(37);             // length item cut short
      send_packet();
      make_spead(2, 0, 32'hFFFF_FFFF, 8);
      send_packet();
      make_spead(2, 0, 20, 20);
      packet_bytes[6] = 8'h80;         // huge item count
      send_packet();
      wait_drained();

      random_start    = bytes_sent;
      left_in_setting = 0;
      while (bytes_sent - random_start < 1100) begin
         if (left_in_setting == 0) begin
            wait_drained();
            spead = 1'($urandom_range(1));
            case ($urandom_range(3))
               0: size = '0;
               3: size = spead ? COUNT_W'(MAX_PACKET_BYTES) : COUNT_W'($urandom_range(1, 64));
               default: size = COUNT_W'($urandom_range(1, 64));
            endcase
            write_config(spead, size);
            left_in_setting = $urandom_range(4, 12);
         end
         steady = (bytes_sent - random_start >= 600) && (bytes_sent - random_start < 1000);
         if (!spead) begin
            random_fixed_packet((size != 0) ? size : tracker.learned_size);
         end else if ($urandom_range(99) < 8) begin
            fill_random($urandom_range(1, 3));
         end else begin
            random_spead_packet();
         end
         send_packet();
         left_in_setting--;
      end
      steady = 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d bytes in %0d packets: %0d rejected, %0d SPEAD accepted",
               bytes_sent, tracker.packets, tracker.rejected, tracker.spead_accepts);
      $display("%0d oversized packets, %0d mismatches",
               tracker.saturated, tracker.mismatches);
      if (tracker.mismatches == 0 && tracker.pending_verdicts.size() == 0)
         $display("PASS udp_packet_size_checker_unit");
      else
         $display("FAIL udp_packet_size_checker_unit");
      $finish;
   end

   initial begin
      #15_000_000;
      $display("timeout with %0d verdicts outstanding", tracker.pending_verdicts.size());
      $display("FAIL udp_packet_size_checker_unit");
      $finish;
   end

endmodule
